/* rtl/base64_codec_top_defines.svh */
// assertion macros shared by the base64 codec rtl
// no dependencies; define ASSERT_OFF to compile the checks out
`ifndef BASE64_CODEC_TOP_DEFINES_SVH
`define BASE64_CODEC_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// property that must hold at every clock edge outside reset
`define B64C_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("b64c assertion failed");
// condition in one cycle implies a result in the next
`define B64C_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("b64c assertion failed");
`else
`define B64C_ASSERT(label, clk, rst, prop)
`define B64C_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

/* rtl/b64c_pkg.sv */
// shared types, constants and alphabet functions of the base64 codec
// no dependencies
package b64c_pkg;

   localparam int QUEUE_DEPTH = 2;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [7:0] PAD_CHAR      = 8'h3D;
   localparam logic [7:0] CHAR_UPPER_A  = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z  = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A  = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z  = 8'h7A;
   localparam logic [7:0] CHAR_DIGIT_0  = 8'h30;
   localparam logic [7:0] CHAR_DIGIT_9  = 8'h39;
   localparam logic [7:0] CHAR_PLUS     = 8'h2B;
   localparam logic [7:0] CHAR_SLASH    = 8'h2F;
   localparam logic [7:0] LOWER_OFFSET  = 8'd26;
   localparam logic [7:0] DIGIT_OFFSET  = 8'd52;
   localparam logic [5:0] VALUE_PLUS    = 6'd62;
   localparam logic [5:0] VALUE_SLASH   = 6'd63;

   typedef enum logic {
      DIR_ENCODE = 1'b0,
      DIR_DECODE = 1'b1
   } dir_type;

   typedef enum logic [0:0] {
      REG_DIRECTION = 1'b0
   } reg_index_type;

   // one accepted request turned into up to four results
   typedef struct packed {
      logic [3:0][7:0] data;
      logic [1:0]      last_idx;
      logic            data_valid;
      logic            last;
   } job_type;

   // 6-bit group to alphabet character
   function automatic logic [7:0] b64c_encode_char(input logic [5:0] idx);
      logic [7:0] wide;
      logic [7:0] chr;
      wide = {2'b00, idx};
      case (idx) inside
         [6'd0:6'd25]:  chr = CHAR_UPPER_A + wide;
         [6'd26:6'd51]: chr = CHAR_LOWER_A + wide - LOWER_OFFSET;
         [6'd52:6'd61]: chr = CHAR_DIGIT_0 + wide - DIGIT_OFFSET;
         VALUE_PLUS:    chr = CHAR_PLUS;
         default:       chr = CHAR_SLASH;
      endcase
      return chr;
   endfunction

   // alphabet character to {valid, 6-bit value}
   function automatic logic [6:0] b64c_decode_char(input logic [7:0] chr);
      logic [7:0] diff;
      logic [6:0] res;
      diff = 8'd0;
      case (chr) inside
         [CHAR_UPPER_A:CHAR_UPPER_Z]: begin
            diff = chr - CHAR_UPPER_A;
            res  = {1'b1, diff[5:0]};
         end
         [CHAR_LOWER_A:CHAR_LOWER_Z]: begin
            diff = chr - CHAR_LOWER_A + LOWER_OFFSET;
            res  = {1'b1, diff[5:0]};
         end
         [CHAR_DIGIT_0:CHAR_DIGIT_9]: begin
            diff = chr - CHAR_DIGIT_0 + DIGIT_OFFSET;
            res  = {1'b1, diff[5:0]};
         end
         CHAR_PLUS:  res = {1'b1, VALUE_PLUS};
         CHAR_SLASH: res = {1'b1, VALUE_SLASH};
         default:    res = 7'd0;
      endcase
      return res;
   endfunction

endpackage

/* rtl/b64c_front.sv */
// front end: accepts requests, keeps the bit accumulator, builds result jobs
// depends on b64c_pkg and base64_codec_top_defines.svh
`include "base64_codec_top_defines.svh"

module b64c_front (
   input  logic             clock,
   input  logic             reset,
   input  b64c_pkg::dir_type direction,
   input  logic             clear,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [7:0]       req_in_byte,
   input  logic             req_msg_end,
   input  logic             q_ready,
   output logic             push,
   output b64c_pkg::job_type job
);
   import b64c_pkg::*;

   logic [5:0] acc_ff, acc_in;
   logic [2:0] pend_ff, pend_in;
   logic [1:0] cm_ff, cm_in;

   logic       accept;

   // encode path
   logic [5:0] enc_c0, enc_c1, enc_flush, enc_s1, enc_acc;
   logic [2:0] enc_pend;
   logic       enc_two, enc_second;
   logic [1:0] enc_chars, enc_cm, enc_pads;
   logic [2:0] enc_total_raw, enc_total;
   job_type    enc_job;

   // decode path
   logic [6:0] dec_lookup;
   logic       dec_ok;
   logic [5:0] dec_v, dec_acc;
   logic [2:0] dec_pend;
   logic [7:0] dec_out;
   logic       dec_have;
   job_type    dec_job;

   assign req_ready = q_ready;
   assign accept    = req_valid & q_ready;

   always_comb begin
      enc_c0    = 6'd0;
      enc_c1    = 6'd0;
      enc_two   = 1'b0;
      enc_acc   = 6'd0;
      enc_pend  = 3'd0;
      enc_flush = 6'd0;
      case (pend_ff)
         3'd0: begin
            enc_c0    = req_in_byte[7:2];
            enc_acc   = {4'b0, req_in_byte[1:0]};
            enc_pend  = 3'd2;
            enc_flush = {req_in_byte[1:0], 4'b0};
         end
         3'd2: begin
            enc_c0    = {acc_ff[1:0], req_in_byte[7:4]};
            enc_acc   = {2'b0, req_in_byte[3:0]};
            enc_pend  = 3'd4;
            enc_flush = {req_in_byte[3:0], 2'b0};
         end
         default: begin
            enc_c0  = {acc_ff[3:0], req_in_byte[7:6]};
            enc_c1  = req_in_byte[5:0];
            enc_two = 1'b1;
         end
      endcase
      // second character is either a full group or the zero-filled flush
      enc_second    = enc_two | (req_msg_end & (enc_pend != 3'd0));
      enc_s1        = enc_two ? enc_c1 : enc_flush;
      enc_chars     = enc_second ? 2'd2 : 2'd1;
      enc_cm        = cm_ff + enc_chars;
      enc_pads      = req_msg_end ? (2'd0 - enc_cm) : 2'd0;
      enc_total_raw = {1'b0, enc_chars} + {1'b0, enc_pads};
      enc_total     = (enc_total_raw > 3'd4) ? 3'd4 : enc_total_raw;

      enc_job.data[0]    = b64c_encode_char(enc_c0);
      enc_job.data[1]    = enc_second ? b64c_encode_char(enc_s1) : PAD_CHAR;
      enc_job.data[2]    = PAD_CHAR;
      enc_job.data[3]    = PAD_CHAR;
      enc_job.last_idx   = 2'(enc_total - 3'd1);
      enc_job.data_valid = 1'b1;
      enc_job.last       = req_msg_end;
   end

   always_comb begin
      dec_lookup = b64c_decode_char(req_in_byte);
      dec_ok     = dec_lookup[6];
      dec_v      = dec_lookup[5:0];
      dec_acc    = acc_ff;
      dec_pend   = pend_ff;
      dec_out    = 8'd0;
      dec_have   = 1'b0;
      if (dec_ok) begin
         case (pend_ff)
            3'd0: begin
               dec_acc  = dec_v;
               dec_pend = 3'd6;
            end
            3'd2: begin
               dec_out  = {acc_ff[1:0], dec_v};
               dec_have = 1'b1;
               dec_pend = 3'd0;
            end
            3'd4: begin
               dec_out  = {acc_ff[3:0], dec_v[5:2]};
               dec_have = 1'b1;
               dec_acc  = {4'b0, dec_v[1:0]};
               dec_pend = 3'd2;
            end
            default: begin
               dec_out  = {acc_ff[5:0], dec_v[5:4]};
               dec_have = 1'b1;
               dec_acc  = {2'b0, dec_v[3:0]};
               dec_pend = 3'd4;
            end
         endcase
      end
      dec_job.data       = {8'd0, 8'd0, 8'd0, dec_out};
      dec_job.last_idx   = 2'd0;
      dec_job.data_valid = dec_have;
      dec_job.last       = req_msg_end;
   end

   always_comb begin
      if (direction == DIR_DECODE) begin
         job  = dec_job;
         push = accept & (dec_have | req_msg_end);
      end else begin
         job  = enc_job;
         push = accept;
      end
   end

   always_comb begin
      acc_in  = acc_ff;
      pend_in = pend_ff;
      cm_in   = cm_ff;
      if (clear || (accept && req_msg_end)) begin
         acc_in  = 6'd0;
         pend_in = 3'd0;
         cm_in   = 2'd0;
      end else if (accept) begin
         if (direction == DIR_DECODE) begin
            acc_in  = dec_acc;
            pend_in = dec_pend;
         end else begin
            acc_in  = enc_acc;
            pend_in = enc_pend;
            cm_in   = enc_cm;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= 6'd0;
         pend_ff <= 3'd0;
         cm_ff   <= 2'd0;
      end else begin
         acc_ff  <= acc_in;
         pend_ff <= pend_in;
         cm_ff   <= cm_in;
      end
   end

   `B64C_ASSERT(a_pend_even, clock, reset, !pend_ff[0])
   `B64C_ASSERT_NEXT(a_end_clears, clock, reset, accept && req_msg_end, pend_ff == 3'd0 && cm_ff == 2'd0)

endmodule

/* rtl/b64c_queue.sv */
// small job queue between the front end and the result serializer
// depends on b64c_pkg and base64_codec_top_defines.svh
`include "base64_codec_top_defines.svh"

module b64c_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  b64c_pkg::job_type push_job,
   output logic              in_ready,
   input  logic              pop,
   output b64c_pkg::job_type pop_job,
   output logic              out_valid
);
   import b64c_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

   job_type           slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign in_ready  = (count_ff != CNT_FULL);
   assign out_valid = (count_ff != '0);
   assign do_push   = push & in_ready;
   assign do_pop    = pop & out_valid;
   assign pop_job   = slot_ff[rd_ff];

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_in = (wr_ff == PTR_LAST) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == PTR_LAST) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   `B64C_ASSERT(a_count_range, clock, reset, count_ff <= CNT_FULL)

endmodule

/* rtl/b64c_back.sv */
// back end: steps through the results of one job, one per cycle while rsp_ready is high
// depends on b64c_pkg and base64_codec_top_defines.svh
`include "base64_codec_top_defines.svh"

module b64c_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  b64c_pkg::job_type q_job,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [7:0]        rsp_out_byte,
   output logic              rsp_byte_valid,
   output logic              rsp_out_last
);
   import b64c_pkg::*;

   job_type    cur_ff, cur_in;
   logic       busy_ff, busy_in;
   logic [1:0] idx_ff, idx_in;
   logic       take, done_job;

   assign take     = busy_ff & rsp_ready;
   assign done_job = take & (idx_ff == cur_ff.last_idx);
   assign pop      = q_valid & (!busy_ff | done_job);

   assign rsp_valid      = busy_ff;
   assign rsp_out_byte   = cur_ff.data[idx_ff];
   assign rsp_byte_valid = cur_ff.data_valid;
   assign rsp_out_last   = cur_ff.last & (idx_ff == cur_ff.last_idx);

   always_comb begin
      cur_in  = cur_ff;
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (pop) begin
         cur_in  = q_job;
         busy_in = 1'b1;
         idx_in  = 2'd0;
      end else if (done_job) begin
         busy_in = 1'b0;
      end else if (take) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= 2'd0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   `B64C_ASSERT(a_idx_range, clock, reset, !busy_ff || idx_ff <= cur_ff.last_idx)
   `B64C_ASSERT(a_marker_single, clock, reset, !busy_ff || cur_ff.data_valid || (cur_ff.last && cur_ff.last_idx == 2'd0))

endmodule

/* rtl/base64_codec_top.sv */
// base64 codec: encode turns every 3 bytes into 4 characters (one character per cycle out of the
// back end while rsp_ready is high, up to 4 results on a message's last byte); decode 1 character
// per cycle while rsp_ready is high. an accepted request that yields a job is written into the queue
// and then loaded into the back end's job register, which raises rsp_valid
// throughput is set by the back end serializer, one result per cycle while rsp_ready is high
// reset: synchronous active high; clears direction (encode), accumulator, queue, output
// depends on b64c_pkg, b64c_front, b64c_queue, b64c_back
module base64_codec_top (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [7:0]                       req_in_byte,
   input  logic                             req_msg_end,
   // result channel
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [7:0]                       rsp_out_byte,
   output logic                             rsp_byte_valid,
   output logic                             rsp_out_last,
   // register port
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [b64c_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [b64c_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [b64c_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);
   import b64c_pkg::*;

   // direction register
   dir_type       dir_ff, dir_in;
   logic          csr_write;
   logic          dir_write;
   reg_index_type csr_index;

   // front to queue
   logic    q_push;
   logic    q_in_ready;
   job_type push_job;

   // queue to back
   logic    q_pop;
   logic    q_valid;
   job_type pop_job;

   // register port: no wait states
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;
   assign csr_index  = reg_index_type'(csr_paddr[2]);

   // decode the register index; writes beyond the list are dropped
   always_comb begin
      dir_write  = 1'b0;
      csr_prdata = '0;
      case (csr_index)
         REG_DIRECTION: begin
            dir_write  = csr_write;
            csr_prdata = {{(CSR_DATA_W-1){1'b0}}, dir_ff};
         end
         default: begin
            dir_write  = 1'b0;
            csr_prdata = '0;
         end
      endcase
   end

   assign dir_in = dir_write ? dir_type'(csr_pwdata[0]) : dir_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff <= DIR_ENCODE;
      end else begin
         dir_ff <= dir_in;
      end
   end

   // front end: accepts requests and builds one job per request that yields results;
   // a direction write also clears the accumulator state
   b64c_front u_front (
      .clock       (clock),
      .reset       (reset),
      .direction   (dir_ff),
      .clear       (dir_write),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_in_byte (req_in_byte),
      .req_msg_end (req_msg_end),
      .q_ready     (q_in_ready),
      .push        (q_push),
      .job         (push_job)
   );

   // queue lets the front keep accepting while the back drains a job
   b64c_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_job  (push_job),
      .in_ready  (q_in_ready),
      .pop       (q_pop),
      .pop_job   (pop_job),
      .out_valid (q_valid)
   );

   // back end: holds the job in a register and hands out one result per cycle while rsp_ready is high
   b64c_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_job          (pop_job),
      .pop            (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_out_last   (rsp_out_last)
   );

endmodule
